// ===== hdl/adcthd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adcthd_pkg;

    // Field widths of the request and result items.
    localparam int ADC_W   = 10;
    localparam int SCALE_W = 10;
    localparam int BAND_W  = 4;
    localparam int TEMP_W  = 10;
    localparam int SEG_W   = 7;
    localparam int EN_W    = 2;
    localparam int SHOWN_W = 7;
    localparam int DIGIT_W = 4;
    localparam int PROD_W  = ADC_W + SCALE_W;

    // Command codes carried in the request.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Digit enable codes.
    localparam logic [EN_W-1:0] EN_NONE  = 2'd0;
    localparam logic [EN_W-1:0] EN_TENS  = 2'd1;
    localparam logic [EN_W-1:0] EN_UNITS = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_BAND  = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd500;
    localparam logic [BAND_W-1:0]  BAND_RESET  = 4'd1;

    // Largest value the two digits can show.
    localparam logic [SHOWN_W-1:0] SHOWN_MAX = 7'd99;
    // Saturation limit of the scaled reading.
    localparam logic [PROD_W-1:0]  TEMP_SAT  = PROD_W'(1023);
    // Reciprocal of ten for values below 1024: (x * 205) >> 11.
    localparam logic [7:0]         RECIP_10  = 8'd205;
    localparam int                 RECIP_SH  = 11;

    typedef struct packed {
        logic              cmd;
        logic [ADC_W-1:0]  adc_sample;
    } in_item_t;

    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [EN_W-1:0]    digit_enable;
        logic [SHOWN_W-1:0] shown_temperature;
    } out_item_t;

    // Seven-segment decode, bit 0 is segment a. Codes above nine are dark.
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h67;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/adc_thermometer_two_digit_display.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                      | Contents
// ---------+----------------------------+------------------------------------
// request  | s_valid, s_ready, s_data   | cmd and adc_sample (in_item_t)
// result   | m_valid, m_ready, m_data   | segments, digit_enable, shown value
// config   | psel..pready (APB)         | scale_numerator at 0, band at 4
//
// Every request passes three registers in order: the product register loads at the
// edge that takes it, then the clamp and divide-by-ten register, and then the state
// update loads the output register. A new request is taken every cycle while no
// result is held waiting on m_ready.
// The pipeline moves as a whole; it stalls only while a result waits on m_ready.
// Reset is synchronous on aresetn and clears the display state and valid bits.

module adc_thermometer_two_digit_display
    import adcthd_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire in_item_t    s_data,

    output      logic        m_valid,
    input  wire logic        m_ready,
    output      out_item_t   m_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    // Configuration registers.
    logic [SCALE_W-1:0] scale_reg;
    logic [BAND_W-1:0]  band_reg;
    logic               cfg_write;
    logic               cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            band_reg  <= BAND_RESET;
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_SCALE: scale_reg <= pwdata[SCALE_W-1:0];
                REG_BAND:  band_reg  <= pwdata[BAND_W-1:0];
                default:   scale_reg <= scale_reg;
            endcase
        end
    end

    // Register readback, ignoring the byte offset within a word.
    always_comb begin
        case (cfg_sel)
            REG_SCALE: prdata = {{(32-SCALE_W){1'b0}}, scale_reg};
            REG_BAND:  prdata = {{(32-BAND_W){1'b0}}, band_reg};
            default:   prdata = '0;
        endcase
    end

    // The whole pipeline advances unless a result is held by the sink.
    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Stage one: the raw product of reading and scale.
    logic              v1_reg;
    logic              cmd1_reg;
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd1_reg <= s_data.cmd;
            prod_reg <= PROD_W'(s_data.adc_sample) * PROD_W'(scale_reg);
        end
    end

    // Stage two: shift, saturate, clamp to two digits and split them.
    logic [PROD_W-1:0]  scaled;
    logic [TEMP_W-1:0]  temp_next;
    logic [SHOWN_W-1:0] clamp_next;
    logic [14:0]        recip_prod;
    logic [DIGIT_W-1:0] tens_next;
    logic [DIGIT_W-1:0] units_next;

    always_comb begin
        scaled = prod_reg >> ADC_BITS;
        if (scaled > TEMP_SAT) begin
            temp_next = TEMP_SAT[TEMP_W-1:0];
        end else begin
            temp_next = scaled[TEMP_W-1:0];
        end
        if (temp_next > TEMP_W'(SHOWN_MAX)) begin
            clamp_next = SHOWN_MAX;
        end else begin
            clamp_next = temp_next[SHOWN_W-1:0];
        end
        recip_prod = 15'(clamp_next) * 15'(RECIP_10);
        tens_next  = recip_prod[RECIP_SH +: DIGIT_W];
        units_next = 4'(clamp_next - 7'({tens_next, 3'b000} + {2'b00, tens_next, 1'b0}));
    end

    logic               v2_reg;
    logic               cmd2_reg;
    logic [TEMP_W-1:0]  temp2_reg;
    logic [SHOWN_W-1:0] clamp2_reg;
    logic [DIGIT_W-1:0] tens2_reg;
    logic [DIGIT_W-1:0] units2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cmd2_reg   <= cmd1_reg;
            temp2_reg  <= temp_next;
            clamp2_reg <= clamp_next;
            tens2_reg  <= tens_next;
            units2_reg <= units_next;
        end
    end

    // Stage three: hysteresis check, multiplex tick and the result register.
    logic [TEMP_W-1:0]  last_reg,  last_next;
    logic [DIGIT_W-1:0] tens_reg,  tens_upd;
    logic [DIGIT_W-1:0] units_reg, units_upd;
    logic [SHOWN_W-1:0] shown_reg, shown_next;
    logic               units_turn_reg, units_turn_next;
    logic [EN_W-1:0]    en_reg,    en_next;
    logic [SEG_W-1:0]   seg_reg,   seg_next;
    logic signed [TEMP_W:0] diff;
    logic signed [TEMP_W:0] band_s;
    logic               change;

    always_comb begin
        last_next       = last_reg;
        tens_upd        = tens_reg;
        units_upd       = units_reg;
        shown_next      = shown_reg;
        units_turn_next = units_turn_reg;
        en_next         = en_reg;
        seg_next        = seg_reg;
        diff   = $signed({1'b0, temp2_reg}) - $signed({1'b0, last_reg});
        band_s = $signed({{(TEMP_W+1-BAND_W){1'b0}}, band_reg});
        change = (diff > band_s) || (diff < -band_s);
        case (cmd2_reg)
            CMD_SAMPLE: begin
                if (change) begin
                    last_next  = temp2_reg;
                    tens_upd   = tens2_reg;
                    units_upd  = units2_reg;
                    shown_next = clamp2_reg;
                end
            end
            CMD_TICK: begin
                if (!units_turn_reg) begin
                    en_next  = EN_TENS;
                    seg_next = seg_decode(tens_reg);
                end else begin
                    en_next  = EN_UNITS;
                    seg_next = seg_decode(units_reg);
                end
                units_turn_next = !units_turn_reg;
            end
            default: begin
                en_next = en_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg       <= '0;
            tens_reg       <= '0;
            units_reg      <= '0;
            shown_reg      <= '0;
            units_turn_reg <= 1'b0;
            en_reg         <= EN_NONE;
            seg_reg        <= '0;
            m_valid        <= 1'b0;
        end else if (advance) begin
            m_valid <= v2_reg;
            if (v2_reg) begin
                last_reg       <= last_next;
                tens_reg       <= tens_upd;
                units_reg      <= units_upd;
                shown_reg      <= shown_next;
                units_turn_reg <= units_turn_next;
                en_reg         <= en_next;
                seg_reg        <= seg_next;
            end
        end
    end

    // The result fields follow the display state loaded with the result.
    assign m_data.segments          = seg_reg;
    assign m_data.digit_enable      = en_reg;
    assign m_data.shown_temperature = shown_reg;

endmodule

`default_nettype wire

// ===== sim/display_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and configuration ports of the thermometer display,
// keeps its own copy of the display state and checks every result in order.
module display_checker
    import adcthd_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire in_item_t    s_data,

    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire out_item_t   m_data,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,

    output int               pending,
    output int               failures
);

    // Segment patterns for digits 0..15, digit 0 in the lowest slice; codes above
    // nine stay dark.
    localparam logic [16*SEG_W-1:0] GLYPHS = {
        {6{7'h00}}, 7'h67, 7'h7F, 7'h07, 7'h7D, 7'h6D,
        7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };
    localparam int unsigned SCALED_SAT = 1023;

    // Shadow copies of the registers and of the display state.
    logic [SCALE_W-1:0] scale;
    logic [BAND_W-1:0]  band;
    logic [TEMP_W-1:0]  held_temp;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] units;
    logic               units_next;
    logic [EN_W-1:0]    lit_enable;
    logic [SEG_W-1:0]   lit_segments;

    out_item_t expected_display[$];

    // Applies one request to the display state and returns the result it gives.
    task automatic advance_display(input in_item_t req, output out_item_t res);
        int unsigned scaled;
        int          delta;
        if (req.cmd == CMD_SAMPLE) begin
            scaled = req.adc_sample * scale;
            scaled = scaled >> ADC_BITS;
            if (scaled > SCALED_SAT) begin
                scaled = SCALED_SAT;
            end
            // The shown digits move only when the change leaves the band.
            delta = int'(scaled) - int'(held_temp);
            if (delta > int'(band) || delta < -int'(band)) begin
                held_temp = TEMP_W'(scaled);
                if (scaled > SHOWN_MAX) begin
                    tens  = 4'd9;
                    units = 4'd9;
                end else begin
                    tens  = DIGIT_W'(scaled / 10);
                    units = DIGIT_W'(scaled % 10);
                end
            end
        end else if (!units_next) begin
            lit_enable   = EN_TENS;
            lit_segments = GLYPHS[tens*SEG_W +: SEG_W];
            units_next   = 1'b1;
        end else begin
            lit_enable   = EN_UNITS;
            lit_segments = GLYPHS[units*SEG_W +: SEG_W];
            units_next   = 1'b0;
        end
        res.segments          = lit_segments;
        res.digit_enable      = lit_enable;
        res.shown_temperature = SHOWN_W'(tens * 10 + units);
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t prediction;
        if (!aresetn) begin
            scale        = SCALE_RESET;
            band         = BAND_RESET;
            held_temp    = '0;
            tens         = '0;
            units        = '0;
            units_next   = 1'b0;
            lit_enable   = EN_NONE;
            lit_segments = '0;
            expected_display.delete();
        end else begin
            // Register writes land on the access cycle.
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SCALE) begin
                    scale = pwdata[SCALE_W-1:0];
                end else begin
                    band = pwdata[BAND_W-1:0];
                end
            end

            // A result always belongs to a request taken at an earlier edge.
            if (m_valid && m_ready) begin
                if (expected_display.size() == 0) begin
                    $error("unexpected result %h with no request outstanding", m_data);
                    failures++;
                end else begin
                    want = expected_display.pop_front();
                    if (m_data.segments !== want.segments) begin
                        $error("segments: expected %h, got %h",
                               want.segments, m_data.segments);
                        failures++;
                    end
                    if (m_data.digit_enable !== want.digit_enable) begin
                        $error("digit_enable: expected %0d, got %0d",
                               want.digit_enable, m_data.digit_enable);
                        failures++;
                    end
                    if (m_data.shown_temperature !== want.shown_temperature) begin
                        $error("shown_temperature: expected %0d, got %0d",
                               want.shown_temperature, m_data.shown_temperature);
                        failures++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                advance_display(s_data, prediction);
                expected_display.push_back(prediction);
            end
        end
        pending = expected_display.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import adcthd_pkg::*;

    localparam int ADC_BITS    = 10;
    localparam int PERIOD      = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 10;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int          pending;
    int          failures;
    int          cycle_count;
    logic        steady = 1'b0;
    logic [ADC_W-1:0] last_adc = '0;

    always #(PERIOD / 2) aclk = ~aclk;

    adc_thermometer_two_digit_display #(
        .ADC_BITS (ADC_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    display_checker #(
        .ADC_BITS (ADC_BITS)
    ) u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pending  (pending),
        .failures (failures)
    );

    // The result side stalls at random except during the steady stretch.
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 36);
        end
    end

    // Presents one request and returns at the edge that takes it.
    task automatic send_req(input logic cmd, input logic [ADC_W-1:0] adc);
        while (!steady && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data.cmd        <= cmd;
        s_data.adc_sample <= adc;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // Waits for the block to drain, then writes one register.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (5) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random samples and ticks; samples are drawn from the whole range, from the
    // range 0 to 260, or close to the previous reading so that
    // the hysteresis band is exercised.
    task automatic run_random(input int count);
        int               mode;
        int               near;
        logic [ADC_W-1:0] adc;
        repeat (count) begin
            mode = $urandom_range(9);
            if (mode < 4) begin
                adc = ADC_W'($urandom_range(1023));
            end else if (mode < 8) begin
                adc = ADC_W'($urandom_range(260));
            end else begin
                near = int'(last_adc) + int'($urandom_range(24)) - 12;
                if (near < 0) begin
                    near = 0;
                end
                if (near > 1023) begin
                    near = 1023;
                end
                adc = ADC_W'(near);
            end
            if ($urandom_range(1) == 0) begin
                last_adc = adc;
                send_req(CMD_SAMPLE, adc);
            end else begin
                send_req(CMD_TICK, adc);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests with the reset scale of 500 and band of 1.
        send_req(CMD_SAMPLE, 10'd0);    // result before any tick: all dark
        send_req(CMD_TICK,   10'd0);    // tens lit with zero
        send_req(CMD_SAMPLE, 10'd1023); // far above two digits: shows 99
        send_req(CMD_TICK,   10'h3FF);  // units lit with nine
        send_req(CMD_TICK,   10'd0);
        send_req(CMD_SAMPLE, 10'd2);    // scales to zero: shows 00
        send_req(CMD_SAMPLE, 10'd21);   // 10 degrees
        send_req(CMD_SAMPLE, 10'd23);   // 11: inside the band, held
        send_req(CMD_SAMPLE, 10'd25);   // 12: leaves the band
        send_req(CMD_TICK,   10'd0);
        send_req(CMD_TICK,   10'd0);
        send_req(CMD_SAMPLE, 10'd205);  // 100: clamps to 99
        send_req(CMD_SAMPLE, 10'd203);  // 99 inside the band of the last value
        send_req(CMD_SAMPLE, 10'd39);   // 19
        send_req(CMD_TICK,   10'd0);
        send_req(CMD_TICK,   10'd0);
        send_req(CMD_TICK,   10'd0);
        send_req(CMD_SAMPLE, 10'h2AA);
        send_req(CMD_SAMPLE, 10'h155);
        send_req(CMD_TICK,   10'h155);
        run_random(300);

        // Largest scale and no band, with no idling on either side.
        write_reg(REG_SCALE, 32'd1023);
        write_reg(REG_BAND, 32'd0);
        steady = 1'b1;
        run_random(200);
        steady = 1'b0;

        // Smallest scale and widest band.
        write_reg(REG_SCALE, 32'd1);
        write_reg(REG_BAND, 32'd15);
        run_random(80);

        write_reg(REG_SCALE, 32'd700);
        write_reg(REG_BAND, 32'd0);
        run_random(150);

        // Two random settings.
        repeat (2) begin
            write_reg(REG_SCALE, 32'($urandom_range(1023, 1)));
            write_reg(REG_BAND, 32'($urandom_range(15)));
            run_random(180);
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN) @(posedge aclk);
        if (failures == 0) begin
            $display("** adc_thermometer_two_digit_display: PASSED **");
        end else begin
            $display("** adc_thermometer_two_digit_display: FAILED **");
        end
        $finish;
    end

    // Stops a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("** adc_thermometer_two_digit_display: FAILED **");
        $finish;
    end

endmodule
